// ===== hw/rtl/block_occupancy_release_scanner_unit_assert.svh =====
// Assertion macros for the occupancy release scanner.
// Used by the top level only; no other dependencies.
`ifndef BLOCK_OCCUPANCY_RELEASE_SCANNER_UNIT_ASSERT_SVH
`define BLOCK_OCCUPANCY_RELEASE_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BORS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bors assertion failed");

// next-cycle implication, checked outside reset
`define BORS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bors assertion failed");

`endif

// ===== hw/rtl/bors_pkg.sv =====
// Shared types and constants for the occupancy release scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bors_pkg;

  localparam int GROUP_COUNT      = 4;
  localparam int BLOCKS_PER_GROUP = 8;
  localparam int OCC_W            = 32;
  localparam int TIMER_W          = 8;
  localparam int TICK_W           = 8;
  localparam int SENSE_W          = 8;
  localparam int ENABLE_W         = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 8;
  localparam int GRP_W            = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  localparam logic [OCC_W-1:0]  OCC_RESET     = 32'h6550_6148;
  localparam logic [TIMER_W-1:0] NOW_RESET    = 8'd1;
  localparam logic [TICK_W-1:0] SCAN_PER_RESET = 8'd4;
  localparam logic [TICK_W-1:0] MS_PER_RESET   = 8'd16;
  localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'hF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PERIOD   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RISE  = 2'd1,
    FUNC_FALL  = 2'd2,
    FUNC_LOAD  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MS,
    ST_SCAN,
    ST_DONE
  } state_e;

  // command from the sequencer to every lane
  typedef struct packed {
    logic               inc_en;
    logic               scan_en;
    logic [GRP_W-1:0]   grp;
    logic [TIMER_W-1:0] now_ms;
  } lane_op_t;

endpackage

// ===== hw/rtl/bors_lane.sv =====
// One timer lane: holds the release timers of one block position in every group.
// Depends on bors_pkg.
`timescale 1ns / 1ps

module bors_lane import bors_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lane_op_t op_i,
  input  logic     sensed_i,
  output logic     hit_o
);

  logic [TIMER_W-1:0] timer_q [GROUP_COUNT];
  logic [TIMER_W-1:0] timer_rd;

  // read the timer of the addressed group
  always_comb begin
    timer_rd = timer_q[op_i.grp];
    hit_o    = !sensed_i && (timer_rd == op_i.now_ms);
  end

  // millisecond increment or reload on a sensed block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        timer_q[g] <= '0;
      end
    end else if (op_i.inc_en) begin
      timer_q[op_i.grp] <= timer_rd + 1'b1;
    end else if (op_i.scan_en && sensed_i) begin
      timer_q[op_i.grp] <= op_i.now_ms - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/bors_merge.sv =====
// Merge stage: folds the lane results of one scan into the occupancy vector.
// Depends on bors_pkg.
`timescale 1ns / 1ps

module bors_merge import bors_pkg::*; (
  input  logic [OCC_W-1:0]            occ_i,
  input  logic [GRP_W-1:0]            grp_i,
  input  logic [BLOCKS_PER_GROUP-1:0] sensed_i,
  input  logic [BLOCKS_PER_GROUP-1:0] hit_i,
  input  logic                        power_i,
  output logic [OCC_W-1:0]            occ_o,
  output logic [OCC_W-1:0]            grp_mask_o
);

  // each vector bit belongs to a fixed group and block position
  for (genvar p = 0; p < OCC_W; p++) begin : g_bit
    localparam int PG = p / BLOCKS_PER_GROUP;
    localparam int PI = p % BLOCKS_PER_GROUP;
    if (PG < GROUP_COUNT) begin : g_used
      logic sel;
      assign sel           = (grp_i == GRP_W'(PG));
      assign grp_mask_o[p] = sel;
      // sensed sets; unsensed with matching timer clears under power
      assign occ_o[p] = sel ? (sensed_i[PI] | (occ_i[p] & !(power_i && hit_i[PI])))
                            : occ_i[p];
    end else begin : g_unused
      assign grp_mask_o[p] = 1'b0;
      assign occ_o[p]      = occ_i[p];
    end
  end

endmodule

// ===== hw/rtl/block_occupancy_release_scanner_unit.sv =====
// Channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// cfg       | cfg_we_i                   | cfg_idx_i, cfg_data_i
// input     | in_valid_i / in_stall_o    | func_i, sense_bits_i, power_ok_i, serial_in_i,
//           |                            | load_level_i
// result    | out_valid_o / out_stall_i  | group_enable_o, serial_out_o, occupancy_o
//
// A serial or load item goes straight to the done state. A base tick first walks all
// GROUP_COUNT groups when a millisecond step falls due (one group of timers per cycle across
// the lanes), then scans one group when a scan falls due, and then goes to the done state.
// Reset is asynchronous, active low, and needs no clearing pass.
// A stalled result sits in the output register while the next item is taken in;
// the block finishes that item only once the register is free.
// Top level; depends on bors_pkg, bors_lane, bors_merge and the assertion header.
`timescale 1ns / 1ps

module block_occupancy_release_scanner_unit import bors_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [SENSE_W-1:0]    sense_bits_i,
  input  logic                  power_ok_i,
  input  logic                  serial_in_i,
  input  logic                  load_level_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ENABLE_W-1:0]   group_enable_o,
  output logic                  serial_out_o,
  output logic [OCC_W-1:0]      occupancy_o
);

  state_e state_q, state_d;

  logic [TICK_W-1:0]           scan_per_q, ms_per_q;
  logic [TICK_W-1:0]           scan_ticks_q, ms_ticks_q;
  logic [OCC_W-1:0]            occ_q;
  logic [TIMER_W-1:0]          now_q;
  logic [GROUP_COUNT-1:0]      missed_q;
  logic [GRP_W-1:0]            scan_grp_q, ms_grp_q;
  logic [OCC_W-1:0]            chain_q;
  logic                        latch_q;
  logic [ENABLE_W-1:0]         enable_q;
  logic                        ms_due_q, scan_due_q, power_q;
  logic [BLOCKS_PER_GROUP-1:0] sensed_q;
  logic                        out_valid_q;

  logic                        in_acc, out_free, out_load;
  logic                        ms_last;
  func_e                       func;
  logic [TICK_W-1:0]           scan_nx, ms_nx;
  logic                        scan_hit, ms_hit;
  logic [GRP_W-1:0]            grp_next;
  logic [ENABLE_W-1:0]         enable_next;
  lane_op_t                    lane_op;
  logic [BLOCKS_PER_GROUP-1:0] hit;
  logic [OCC_W-1:0]            occ_merged, grp_mask;

  assign func     = func_e'(func_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ms_last  = (ms_grp_q == GRP_W'(GROUP_COUNT - 1));

  // tick counters
  always_comb begin
    scan_nx  = scan_ticks_q + 1'b1;
    ms_nx    = ms_ticks_q + 1'b1;
    scan_hit = (scan_nx >= scan_per_q);
    ms_hit   = (ms_nx >= ms_per_q);
  end

  // next scan group and its enable line
  always_comb begin
    grp_next = (scan_grp_q == GRP_W'(GROUP_COUNT - 1)) ? '0 : scan_grp_q + 1'b1;
    for (int k = 0; k < ENABLE_W; k++) begin
      enable_next[k] = (k < GROUP_COUNT) && (grp_next == GRP_W'(k));
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_TICK && ms_hit) begin
            state_d = ST_MS;
          end else if (func == FUNC_TICK && scan_hit) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MS: begin
        if (ms_last) begin
          state_d = scan_due_q ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    out_load       = (state_q == ST_DONE) && out_free;
    lane_op.inc_en  = (state_q == ST_MS) && missed_q[ms_grp_q];
    lane_op.scan_en = (state_q == ST_SCAN);
    lane_op.grp     = (state_q == ST_MS) ? ms_grp_q : scan_grp_q;
    lane_op.now_ms  = now_q;
  end

  // timer lanes, one per block position
  for (genvar i = 0; i < BLOCKS_PER_GROUP; i++) begin : g_lane
    bors_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (lane_op),
      .sensed_i(sensed_q[i]),
      .hit_o   (hit[i])
    );
  end

  bors_merge u_merge (
    .occ_i     (occ_q),
    .grp_i     (scan_grp_q),
    .sensed_i  (sensed_q),
    .hit_i     (hit),
    .power_i   (power_q),
    .occ_o     (occ_merged),
    .grp_mask_o(grp_mask)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_per_q   <= SCAN_PER_RESET;
      ms_per_q     <= MS_PER_RESET;
      scan_ticks_q <= '0;
      ms_ticks_q   <= '0;
      occ_q        <= OCC_RESET;
      now_q        <= NOW_RESET;
      missed_q     <= '0;
      scan_grp_q   <= '0;
      ms_grp_q     <= '0;
      chain_q      <= '0;
      latch_q      <= 1'b0;
      enable_q     <= ENABLE_RESET;
      ms_due_q     <= 1'b0;
      scan_due_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCAN_PERIOD: scan_per_q <= cfg_data_i;
          CFG_MS_PERIOD:   ms_per_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // item intake
      if (in_acc) begin
        case (func)
          FUNC_TICK: begin
            scan_ticks_q <= scan_hit ? '0 : scan_nx;
            ms_ticks_q   <= ms_hit ? (ms_nx - ms_per_q) : ms_nx;
            if (ms_hit) begin
              now_q <= now_q + 1'b1;
            end
            ms_due_q   <= ms_hit;
            scan_due_q <= scan_hit;
            ms_grp_q   <= '0;
          end
          FUNC_RISE: begin
            if (!load_level_i) begin
              chain_q <= {serial_in_i, chain_q[OCC_W-1:1]};
            end
          end
          FUNC_FALL: latch_q <= chain_q[0];
          FUNC_LOAD: chain_q <= occ_q;
          default: ;
        endcase
      end

      // millisecond walk over the groups
      if (state_q == ST_MS) begin
        ms_grp_q <= ms_grp_q + 1'b1;
        if (ms_last) begin
          missed_q <= '1;
        end
      end

      // scan of one group
      if (state_q == ST_SCAN) begin
        occ_q      <= occ_merged;
        scan_grp_q <= grp_next;
        enable_q   <= enable_next;
        if (power_q) begin
          missed_q[scan_grp_q] <= 1'b0;
        end
      end

      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sensed_q <= ~sense_bits_i[BLOCKS_PER_GROUP-1:0];
      power_q  <= power_ok_i;
    end
    if (out_load) begin
      group_enable_o <= enable_q;
      serial_out_o   <= latch_q;
      occupancy_o    <= occ_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `include "block_occupancy_release_scanner_unit_assert.svh"

  `BORS_ASSERT_NEXT(a_ms_rearms, clk_i, rst_ni, (state_q == ST_MS) && ms_last, missed_q == '1)
  `BORS_ASSERT_NEXT(a_scan_local, clk_i, rst_ni, state_q == ST_SCAN, ((occ_q ^ $past(occ_q)) & ~$past(grp_mask)) == '0)
  `BORS_ASSERT_NEXT(a_scan_enable, clk_i, rst_ni, state_q == ST_SCAN, $onehot0(enable_q))
  `BORS_ASSERT_NOW(a_intake_idle, clk_i, rst_ni, (state_q == ST_MS) || (state_q == ST_SCAN), ms_due_q || scan_due_q)

endmodule
